// ----- rtl/mvp_pkg.sv -----
package mvp_pkg;

    localparam int MVP_MAX_DIM_DEFAULT = 256;

    localparam int CFG_W   = 9;
    localparam int VAL_W   = 16;
    localparam int ACC_W   = 40;
    localparam int IDX_W   = 8;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [1:0] {
        REG_NUM_ROWS  = 2'd0,
        REG_NUM_COLS  = 2'd1,
        REG_TRANSPOSE = 2'd2
    } mvp_reg_t;

    typedef struct packed {
        logic             load;
        logic             transpose;
        logic             clear_sum;
        logic             emit;
        logic             last;
        logic [IDX_W-1:0] index;
    } mvp_cmd_t;

endpackage

// ----- rtl/mvp_seq.sv -----
module mvp_seq
    import mvp_pkg::*;
#(
    parameter int MAX_DIM = MVP_MAX_DIM_DEFAULT,
    parameter int AW      = $clog2(MAX_DIM)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    input  logic               accept,
    input  logic               kind,
    output mvp_cmd_t           cmd,
    output logic [AW-1:0]      vs_addr,
    output logic [AW-1:0]      cs_addr
);

    localparam int DW = $clog2(MAX_DIM + 1);

    logic [CFG_W-1:0] num_rows_reg;
    logic [CFG_W-1:0] num_cols_reg;
    logic             transpose_reg;
    logic [AW-1:0]    row_pos_reg;
    logic [AW-1:0]    row_pos_next;
    logic [AW-1:0]    col_pos_reg;
    logic [AW-1:0]    col_pos_next;
    logic [AW-1:0]    load_pos_reg;
    logic [AW-1:0]    load_pos_next;
    logic [DW-1:0]    rows_eff;
    logic [DW-1:0]    cols_eff;
    logic [DW-1:0]    load_len;
    logic             row_last;
    logic             col_last;
    logic             load_last;
    logic             cfg_write;
    logic             cfg_restart;
    mvp_reg_t         reg_sel;

    function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] v);
        int unsigned x;
        begin
            x = 32'(v);
            if (x < 1)
            begin
                x = 1;
            end
            else if (x > MAX_DIM)
            begin
                x = MAX_DIM;
            end
            return DW'(x);
        end
    endfunction

    assign reg_sel   = mvp_reg_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite;
    assign cfg_restart = cfg_write && ((reg_sel == REG_NUM_ROWS) || (reg_sel == REG_NUM_COLS)
                                       || (reg_sel == REG_TRANSPOSE));

    assign rows_eff  = eff_dim(num_rows_reg);
    assign cols_eff  = eff_dim(num_cols_reg);
    assign load_len  = transpose_reg ? rows_eff : cols_eff;
    assign row_last  = (DW'(row_pos_reg) + DW'(1)) == rows_eff;
    assign col_last  = (DW'(col_pos_reg) + DW'(1)) == cols_eff;
    assign load_last = (DW'(load_pos_reg) + DW'(1)) == load_len;

    always_comb
    begin
        unique case (reg_sel)
            REG_NUM_ROWS:  prdata = PDATA_W'(num_rows_reg);
            REG_NUM_COLS:  prdata = PDATA_W'(num_cols_reg);
            REG_TRANSPOSE: prdata = PDATA_W'(transpose_reg);
            default:       prdata = '0;
        endcase
    end

    always_comb
    begin
        row_pos_next  = row_pos_reg;
        col_pos_next  = col_pos_reg;
        load_pos_next = load_pos_reg;
        if (cfg_restart)
        begin
            row_pos_next  = '0;
            col_pos_next  = '0;
            load_pos_next = '0;
        end
        else if (accept && !kind)
        begin
            load_pos_next = load_last ? '0 : load_pos_reg + AW'(1);
        end
        else if (accept)
        begin
            col_pos_next = col_last ? '0 : col_pos_reg + AW'(1);
            if (col_last)
            begin
                row_pos_next = row_last ? '0 : row_pos_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg  <= CFG_W'(1);
            num_cols_reg  <= CFG_W'(1);
            transpose_reg <= 1'b0;
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            load_pos_reg  <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (reg_sel)
                    REG_NUM_ROWS:  num_rows_reg  <= pwdata[CFG_W-1:0];
                    REG_NUM_COLS:  num_cols_reg  <= pwdata[CFG_W-1:0];
                    REG_TRANSPOSE: transpose_reg <= pwdata[0];
                    default:       ;
                endcase
            end
            row_pos_reg  <= row_pos_next;
            col_pos_reg  <= col_pos_next;
            load_pos_reg <= load_pos_next;
        end
    end

    always_comb
    begin
        cmd.load      = !kind;
        cmd.transpose = transpose_reg;
        cmd.clear_sum = transpose_reg ? (row_pos_reg == '0) : (col_pos_reg == '0);
        cmd.emit      = transpose_reg ? row_last : col_last;
        cmd.last      = transpose_reg ? col_last : row_last;
        cmd.index     = transpose_reg ? IDX_W'(col_pos_reg) : IDX_W'(row_pos_reg);
    end

    assign vs_addr = !kind ? load_pos_reg : (transpose_reg ? row_pos_reg : col_pos_reg);
    assign cs_addr = col_pos_reg;

endmodule

// ----- rtl/mvp_mac.sv -----
module mvp_mac
    import mvp_pkg::*;
#(
    parameter int MAX_DIM = MVP_MAX_DIM_DEFAULT,
    parameter int AW      = $clog2(MAX_DIM)
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  mvp_cmd_t                cmd,
    input  logic [AW-1:0]           vs_addr,
    input  logic [AW-1:0]           cs_addr,
    input  logic signed [VAL_W-1:0] element_value,
    output logic                    stall,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic signed [ACC_W-1:0] result_value,
    output logic [IDX_W-1:0]        result_index,
    output logic                    last_result
);

    logic signed [VAL_W-1:0]   vs_mem [MAX_DIM];
    logic [ACC_W-1:0]          cs_mem [MAX_DIM];

    logic signed [VAL_W-1:0]   vs_rd_reg;
    logic [ACC_W-1:0]          cs_rd_reg;
    logic                      s1_valid_reg;
    mvp_cmd_t                  s1_cmd_reg;
    logic signed [VAL_W-1:0]   s1_value_reg;
    logic [AW-1:0]             s1_cs_addr_reg;
    logic                      s1_hit_reg;
    logic                      hit_next;
    logic [ACC_W-1:0]          fwd_reg;
    logic [ACC_W-1:0]          running_sum_reg;
    logic                      result_valid_reg;
    logic [ACC_W-1:0]          result_value_reg;
    logic [IDX_W-1:0]          result_index_reg;
    logic                      last_result_reg;

    logic signed [2*VAL_W-1:0] product;
    logic [ACC_W-1:0]          addend;
    logic [ACC_W-1:0]          sum;
    logic                      s1_fire;
    logic                      mat_accept;

    assign mat_accept = accept && !cmd.load;
    assign s1_fire    = s1_valid_reg
                        && (!s1_cmd_reg.emit || !result_valid_reg || !result_stall);
    assign stall      = s1_valid_reg && !s1_fire;

    // A column sum written at the same edge that the next element reads it is
    // taken from the forwarding register instead of the stale memory word.
    assign hit_next = s1_fire && s1_cmd_reg.transpose && (s1_cs_addr_reg == cs_addr);

    assign product = s1_value_reg * vs_rd_reg;

    always_comb
    begin
        priority if (s1_cmd_reg.clear_sum)
        begin
            addend = '0;
        end
        else if (!s1_cmd_reg.transpose)
        begin
            addend = running_sum_reg;
        end
        else if (s1_hit_reg)
        begin
            addend = fwd_reg;
        end
        else
        begin
            addend = cs_rd_reg;
        end
    end

    assign sum = addend + ACC_W'(product);

    always_ff @(posedge clk)
    begin
        if (accept && cmd.load)
        begin
            vs_mem[vs_addr] <= element_value;
        end
        if (mat_accept)
        begin
            vs_rd_reg <= vs_mem[vs_addr];
            cs_rd_reg <= cs_mem[cs_addr];
        end
        if (s1_fire && s1_cmd_reg.transpose)
        begin
            cs_mem[s1_cs_addr_reg] <= sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mat_accept)
        begin
            s1_cmd_reg     <= cmd;
            s1_value_reg   <= element_value;
            s1_cs_addr_reg <= cs_addr;
            s1_hit_reg     <= hit_next;
        end
        if (s1_fire && s1_cmd_reg.transpose)
        begin
            fwd_reg <= sum;
        end
        if (s1_fire && s1_cmd_reg.emit)
        begin
            result_value_reg <= sum;
            result_index_reg <= s1_cmd_reg.index;
            last_result_reg  <= s1_cmd_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            running_sum_reg  <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (mat_accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire && !s1_cmd_reg.transpose)
            begin
                running_sum_reg <= sum;
            end
            if (s1_fire && s1_cmd_reg.emit)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result_value = result_value_reg;
    assign result_index = result_index_reg;
    assign last_result  = last_result_reg;

endmodule

// ----- rtl/matrix_vector_product_core.sv -----
// Streams y = M*x, or y = M^T*x when transpose_reg is set. Vector elements
// (kind 0) are loaded first, then matrix elements (kind 1) in row-major order.
// A new element can be accepted on every clock while item_stall is low. The
// matrix beat that completes a result goes through the multiply-add stage and
// then the output register. Each matrix beat reads one vector word and, in
// transpose mode, one column sum from the block's memories in the accept
// cycle, then does one 16x16 multiply and one 40-bit add in the following
// stage. The input is stalled only while that stage holds a result and the
// output register is full and stalled. Register writes restart the vector
// load and the matrix pass, and must only be made while the block is idle.
// Vector and column-sum memories are not cleared by reset.
module matrix_vector_product_core
    import mvp_pkg::*;
#(
    parameter int MAX_DIM = MVP_MAX_DIM_DEFAULT
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [PADDR_W-1:0]      paddr,
    input  logic [PDATA_W-1:0]      pwdata,
    output logic [PDATA_W-1:0]      prdata,
    output logic                    pready,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  logic                    kind,
    input  logic signed [VAL_W-1:0] element_value,
    output logic                    result_valid,
    input  logic                    result_stall,
    output logic signed [ACC_W-1:0] result_value,
    output logic [IDX_W-1:0]        result_index,
    output logic                    last_result
);

    localparam int AW = $clog2(MAX_DIM);

    mvp_cmd_t      cmd;
    logic [AW-1:0] vs_addr;
    logic [AW-1:0] cs_addr;
    logic          accept;
    logic          stall;

    assign pready     = 1'b1;
    assign item_stall = stall;
    assign accept     = item_valid && !stall;

    mvp_seq #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .accept  (accept),
        .kind    (kind),
        .cmd     (cmd),
        .vs_addr (vs_addr),
        .cs_addr (cs_addr)
    );

    mvp_mac #(
        .MAX_DIM (MAX_DIM),
        .AW      (AW)
    ) u_mac (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .cmd           (cmd),
        .vs_addr       (vs_addr),
        .cs_addr       (cs_addr),
        .element_value (element_value),
        .stall         (stall),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_value  (result_value),
        .result_index  (result_index),
        .last_result   (last_result)
    );

endmodule

// ----- rtl/mvp_checker.sv -----
module mvp_checker
    import mvp_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    item_valid,
    input logic                    item_stall,
    input logic                    kind,
    input logic                    result_valid,
    input logic                    result_stall,
    input logic signed [ACC_W-1:0] result_value,
    input logic [IDX_W-1:0]        result_index,
    input logic                    last_result
);

    // A stalled result beat must hold.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result_value)
            && $stable(result_index) && $stable(last_result))
        else $error("result beat changed while stalled");

    // The input side backs up only behind a full, stalled output register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> result_valid && result_stall)
        else $error("input stalled without output back-pressure");

    // A result leaving an empty output must come from an accepted matrix beat.
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && !item_stall && kind, 2))
        else $error("result without a matching matrix beat");

endmodule

bind matrix_vector_product_core mvp_checker u_mvp_checker (.*);

// ----- verif/mvp_tb_pkg.sv -----
package mvp_tb_pkg;
    import mvp_pkg::*;

    localparam logic KIND_VECTOR = 1'b0;
    localparam logic KIND_MATRIX = 1'b1;
    localparam int   DIM         = MVP_MAX_DIM_DEFAULT;

    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic [IDX_W-1:0] index;
        logic             last;
    } y_elem_t;

    class product_scoreboard;
        logic [CFG_W-1:0]        rows_reg;
        logic [CFG_W-1:0]        cols_reg;
        logic                    transpose;
        logic signed [VAL_W-1:0] x_store [DIM];
        logic signed [ACC_W-1:0] col_sum [DIM];
        logic signed [ACC_W-1:0] row_acc;
        int                      row_pos;
        int                      col_pos;
        int                      load_pos;
        y_elem_t                 expected_y [$];
        int                      errors;
        int                      checked;

        function new();
            rows_reg  = 1;
            cols_reg  = 1;
            transpose = 1'b0;
            errors    = 0;
            checked   = 0;
            foreach (x_store[i])
            begin
                x_store[i] = '0;
                col_sum[i] = '0;
            end
            restart();
        endfunction

        static function int used_dim(logic [CFG_W-1:0] v);
            if (v == 0)
                return 1;
            if (v > DIM)
                return DIM;
            return int'(v);
        endfunction

        function void restart();
            row_acc  = '0;
            row_pos  = 0;
            col_pos  = 0;
            load_pos = 0;
        endfunction

        function void set_register(mvp_reg_t r, logic [PDATA_W-1:0] d);
            case (r)
                REG_NUM_ROWS:  rows_reg  = d[CFG_W-1:0];
                REG_NUM_COLS:  cols_reg  = d[CFG_W-1:0];
                REG_TRANSPOSE: transpose = d[0];
                default:       return;
            endcase
            restart();
        endfunction

        function int pending();
            return expected_y.size();
        endfunction

        function void take_element(logic k, logic signed [VAL_W-1:0] v);
            int                      rows;
            int                      cols;
            int                      len;
            int                      c;
            logic signed [ACC_W-1:0] a;
            logic signed [ACC_W-1:0] b;
            logic signed [ACC_W-1:0] prev;
            y_elem_t                 y;
            rows = used_dim(rows_reg);
            cols = used_dim(cols_reg);
            if (row_pos >= rows)
                row_pos = 0;
            if (col_pos >= cols)
                col_pos = 0;
            a = v;
            if (k == KIND_VECTOR)
            begin
                len = transpose ? rows : cols;
                if (load_pos >= len)
                    load_pos = 0;
                x_store[load_pos] = v;
                load_pos = (load_pos + 1 >= len) ? 0 : load_pos + 1;
                return;
            end
            if (!transpose)
            begin
                b = x_store[col_pos];
                row_acc = row_acc + a * b;
                col_pos++;
                if (col_pos < cols)
                    return;
                y.value = row_acc;
                y.index = IDX_W'(row_pos);
                y.last  = (row_pos + 1 == rows);
                expected_y.push_back(y);
                row_acc = '0;
                col_pos = 0;
                row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
            end
            else
            begin
                c = col_pos;
                b = x_store[row_pos];
                prev = (row_pos == 0) ? '0 : col_sum[c];
                col_sum[c] = prev + a * b;
                if (row_pos + 1 == rows)
                begin
                    y.value = col_sum[c];
                    y.index = IDX_W'(c);
                    y.last  = (c + 1 == cols);
                    expected_y.push_back(y);
                end
                col_pos++;
                if (col_pos >= cols)
                begin
                    col_pos = 0;
                    row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
                end
            end
        endfunction

        function void check_output(logic [ACC_W-1:0] value, logic [IDX_W-1:0] index,
                                   logic last);
            y_elem_t y;
            if (expected_y.size() == 0)
            begin
                $error("result with no expectation: value %0d index %0d",
                       $signed(value), index);
                errors++;
                return;
            end
            y = expected_y.pop_front();
            checked++;
            if (value !== y.value)
            begin
                $error("result_value: expected %0d, got %0d", $signed(y.value),
                       $signed(value));
                errors++;
            end
            if (index !== y.index)
            begin
                $error("result_index: expected %0d, got %0d", y.index, index);
                errors++;
            end
            if (last !== y.last)
            begin
                $error("last_result: expected %0d, got %0d", y.last, last);
                errors++;
            end
        endfunction
    endclass

endpackage

// ----- verif/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mvp_pkg::*;
    import mvp_tb_pkg::*;

    localparam int DRAIN       = 8;
    localparam int HOLD_CYCLES = 200;
    localparam int ITEM_TARGET = 700;

    logic                    clk;
    logic                    rst_n         = 1'b0;
    logic                    psel          = 1'b0;
    logic                    penable       = 1'b0;
    logic                    pwrite        = 1'b0;
    logic [PADDR_W-1:0]      paddr         = '0;
    logic [PDATA_W-1:0]      pwdata        = '0;
    logic [PDATA_W-1:0]      prdata;
    logic                    pready;
    logic                    item_valid    = 1'b0;
    logic                    item_stall;
    logic                    kind          = KIND_VECTOR;
    logic signed [VAL_W-1:0] element_value = '0;
    logic                    result_valid;
    logic                    result_stall  = 1'b0;
    logic signed [ACC_W-1:0] result_value;
    logic [IDX_W-1:0]        result_index;
    logic                    last_result;

    product_scoreboard sb;
    bit idle_in      = 1'b1;
    bit idle_out     = 1'b1;
    bit hold_request = 1'b0;
    bit stall_hold   = 1'b0;
    int items_sent   = 0;
    int input_stalls = 0;
    int settings     = 0;
    int loaded_len   = 0;

    matrix_vector_product_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .kind          (kind),
        .element_value (element_value),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .result_value  (result_value),
        .result_index  (result_index),
        .last_result   (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL matrix_vector_product_core");
        $finish;
    end

    function automatic logic signed [VAL_W-1:0] element_draw();
        case ($urandom_range(0, 11))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0001;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    task automatic send_element(input logic k, input logic signed [VAL_W-1:0] v);
        int gap;
        gap = idle_in ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid    <= 1'b1;
        kind          <= k;
        element_value <= v;
        @(posedge clk);
        while (item_stall)
        begin
            input_stalls++;
            @(posedge clk);
        end
        sb.take_element(k, v);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input mvp_reg_t r, input logic [PDATA_W-1:0] d);
        logic [PDATA_W-1:0] keep;
        keep = (r == REG_TRANSPOSE) ? PDATA_W'(d[0]) : PDATA_W'(d[CFG_W-1:0]);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(int'(r) * 4);
        pwdata  <= d;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_register(r, d);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== keep)
        begin
            $error("prdata: expected %0d, got %0d", keep, prdata);
            sb.errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] rows_w, input logic [CFG_W-1:0] cols_w,
                             input logic tr);
        logic [PDATA_W-1:0] junk;
        wait_idle();
        junk = $urandom;
        write_reg(REG_NUM_ROWS, {junk[PDATA_W-1:CFG_W], rows_w});
        junk = $urandom;
        write_reg(REG_NUM_COLS, {junk[PDATA_W-1:CFG_W], cols_w});
        junk = $urandom;
        write_reg(REG_TRANSPOSE, {junk[PDATA_W-1:1], tr});
        settings++;
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] rows_w, input logic [CFG_W-1:0] cols_w,
                             input logic tr, input int matrices, input bit squeeze);
        int rows;
        int cols;
        int len;
        int beats;
        rows = product_scoreboard::used_dim(rows_w);
        cols = product_scoreboard::used_dim(cols_w);
        len  = tr ? rows : cols;
        configure(rows_w, cols_w, tr);
        idle_in  = squeeze ? 1'b0 : ($urandom_range(0, 3) != 0);
        idle_out = ($urandom_range(0, 3) != 0);
        if (len > loaded_len || $urandom_range(0, 2) != 0)
        begin
            for (int i = 0; i < len; i++)
                send_element(KIND_VECTOR, element_draw());
            if (len > loaded_len)
                loaded_len = len;
        end
        if (squeeze)
            hold_request = 1'b1;
        beats = matrices * rows * cols;
        if (rows * cols > 1 && $urandom_range(0, 3) == 0)
            beats += $urandom_range(1, rows * cols - 1);
        for (int i = 0; i < beats; i++)
        begin
            if (!squeeze && $urandom_range(0, 24) == 0)
                send_element(KIND_VECTOR, element_draw());
            send_element(KIND_MATRIX, element_draw());
        end
    endtask

    function automatic logic [CFG_W-1:0] dim_draw();
        if ($urandom_range(0, 5) == 0)
            return CFG_W'($urandom_range(7, 16));
        return CFG_W'($urandom_range(0, 6));
    endfunction

    initial
    begin : long_hold
        wait (hold_request);
        @(posedge clk);
        stall_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_hold = 1'b0;
    end

    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                sb.check_output(result_value, result_index, last_result);
                stall_left = idle_out ? $urandom_range(0, 8) : 0;
            end
            @(negedge clk);
            result_stall <= stall_hold || (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial
    begin : stimulus
        sb = new();
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Extreme products, and a fourth load that wraps back to the first entry.
        configure(9'd2, 9'd3, 1'b0);
        send_element(KIND_VECTOR, 16'h7FFF);
        send_element(KIND_VECTOR, 16'h8000);
        send_element(KIND_VECTOR, 16'h0001);
        send_element(KIND_VECTOR, 16'h8000);
        loaded_len = 3;
        send_element(KIND_MATRIX, 16'h8000);
        send_element(KIND_MATRIX, 16'h8000);
        send_element(KIND_MATRIX, 16'h7FFF);
        send_element(KIND_MATRIX, 16'h7FFF);
        send_element(KIND_MATRIX, 16'h7FFF);
        send_element(KIND_MATRIX, 16'hFFFF);

        // Transpose pass, then a partial matrix cut short by a register write.
        configure(9'd3, 9'd2, 1'b1);
        send_element(KIND_VECTOR, 16'h8000);
        send_element(KIND_VECTOR, 16'h7FFF);
        send_element(KIND_VECTOR, 16'h0100);
        send_element(KIND_MATRIX, 16'h8000);
        send_element(KIND_MATRIX, 16'h7FFF);
        send_element(KIND_MATRIX, 16'h8000);
        send_element(KIND_MATRIX, 16'h8000);
        send_element(KIND_MATRIX, 16'h0001);
        send_element(KIND_MATRIX, 16'hFFFF);
        send_element(KIND_MATRIX, 16'h1234);
        send_element(KIND_MATRIX, 16'h5678);

        // Zero dimensions act as one; the stored vector is first reused without a reload, then replaced.
        configure(9'd0, 9'd0, 1'b0);
        send_element(KIND_MATRIX, 16'hFFFF);
        send_element(KIND_MATRIX, 16'h0100);
        send_element(KIND_VECTOR, 16'h7FFF);
        send_element(KIND_MATRIX, 16'h8000);

        run_phase(9'd511, 9'd1, 1'b0, 1, 1'b1);
        run_phase(9'd0, 9'd256, 1'b1, 1, 1'b0);
        while (items_sent < ITEM_TARGET)
            run_phase(dim_draw(), dim_draw(), 1'($urandom_range(0, 1)),
                      $urandom_range(1, 3), 1'b0);

        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);

        $display("Streamed %0d beats over %0d register settings in both modes;",
                 items_sent, settings);
        $display("checked %0d output elements, input held back for %0d cycles.",
                 sb.checked, input_stalls);
        if (sb.errors == 0)
            $display("PASS matrix_vector_product_core");
        else
            $display("FAIL matrix_vector_product_core");
        $finish;
    end

endmodule
